@@ design/zmes_pkg.sv @@
// Package with the shared types and constants of the zone-metered exposure stepper.
package zmes_pkg;

	// Field widths.
	localparam int LEVEL_W  = 8;
	localparam int COL_W    = 4;
	localparam int LEN_W    = 5;
	localparam int SCORE_W  = 8;
	localparam int EXP_W    = 10;
	localparam int STEP_W   = 8;
	localparam int CFG_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 24;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_LENGTH     = 3'd0,
		REG_WINDOW_OFFSET  = 3'd1,
		REG_WINDOW_WIDTH   = 3'd2,
		REG_LOW_THRESHOLD  = 3'd3,
		REG_HIGH_THRESHOLD = 3'd4,
		REG_OVER_LIMIT     = 3'd5,
		REG_UNDER_LIMIT    = 3'd6,
		REG_STEP_SIZE      = 3'd7
	} reg_idx_t;

	// Frame verdict codes.
	typedef enum logic [1:0] {
		VERDICT_OK    = 2'd0,
		VERDICT_OVER  = 2'd1,
		VERDICT_UNDER = 2'd2
	} verdict_t;

	// Configuration register set.
	typedef struct packed {
		logic [LEN_W-1:0]          row_length;
		logic [COL_W-1:0]          window_offset;
		logic [LEN_W-1:0]          window_width;
		logic [LEVEL_W-1:0]        low_threshold;
		logic [LEVEL_W-1:0]        high_threshold;
		logic signed [SCORE_W-1:0] over_limit;
		logic signed [SCORE_W-1:0] under_limit;
		logic [STEP_W-1:0]         step_size;
	} cfg_t;

	// Running state carried from item to item.
	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [COL_W-1:0]          column;
		logic [EXP_W-1:0]          exposure;
	} state_t;

	// One result item.
	typedef struct packed {
		verdict_t                  verdict;
		logic signed [SCORE_W-1:0] frame_score;
		logic [EXP_W-1:0]          exposure_value;
	} result_t;

endpackage

@@ design/zmes_eval.sv @@
// Single-pass zone scoring, column advance and end-of-frame exposure step.
module zmes_eval #(
	parameter int unsigned MIN_EXPOSURE_VALUE = 50,
	parameter int unsigned MAX_EXPOSURE_VALUE = 300
) (
	input  zmes_pkg::cfg_t                  cfg,
	input  zmes_pkg::state_t                cur,
	input  logic [zmes_pkg::LEVEL_W-1:0]    level,
	input  logic                            frame_end,
	output zmes_pkg::state_t                nxt,
	output zmes_pkg::result_t               res
);
	import zmes_pkg::*;

	localparam logic [EXP_W-1:0] EXP_MIN = EXP_W'(MIN_EXPOSURE_VALUE);
	localparam logic [EXP_W-1:0] EXP_MAX = EXP_W'(MAX_EXPOSURE_VALUE);

	logic [LEN_W:0]            win_end;
	logic                      in_window;
	logic signed [SCORE_W+1:0] delta;
	logic signed [SCORE_W+1:0] sum_wide;
	logic signed [SCORE_W-1:0] score_new;
	logic [LEN_W-1:0]          len_eff;
	logic [LEN_W-1:0]          col_inc;
	logic [COL_W-1:0]          col_new;
	logic [EXP_W+1:0]          down_floor;
	logic [EXP_W+1:0]          up_sum;
	logic [EXP_W-1:0]          exp_down;
	logic [EXP_W-1:0]          exp_up;
	logic                      is_over;
	logic                      is_under;

	// Window test on the current column.
	always_comb begin
		win_end   = {2'b00, cfg.window_offset} + {1'b0, cfg.window_width};
		in_window = ({2'b00, cur.column} >= {2'b00, cfg.window_offset}) &&
		            ({2'b00, cur.column} < win_end);
	end

	// Zone score and saturating accumulate.
	always_comb begin
		if (level < cfg.low_threshold) begin
			delta = -(SCORE_W+2)'(1);
		end else if (level > cfg.high_threshold) begin
			delta = (SCORE_W+2)'(2);
		end else begin
			delta = (SCORE_W+2)'(1);
		end
		sum_wide = (SCORE_W+2)'(cur.score) + delta;
		if (!in_window) begin
			score_new = cur.score;
		end else if (sum_wide > (SCORE_W+2)'(127)) begin
			score_new = SCORE_W'(127);
		end else if (sum_wide < -(SCORE_W+2)'(128)) begin
			score_new = -SCORE_W'(128);
		end else begin
			score_new = sum_wide[SCORE_W-1:0];
		end
	end

	// Column counter wraps at the effective row length, clamped to 1..16.
	always_comb begin
		if (cfg.row_length == '0) begin
			len_eff = LEN_W'(1);
		end else if (cfg.row_length > LEN_W'(16)) begin
			len_eff = LEN_W'(16);
		end else begin
			len_eff = cfg.row_length;
		end
		col_inc = {1'b0, cur.column} + LEN_W'(1);
		col_new = (col_inc >= len_eff) ? '0 : col_inc[COL_W-1:0];
	end

	// Candidate exposure values for both correction directions.
	always_comb begin
		down_floor = {4'b0000, cfg.step_size} + {2'b00, EXP_MIN};
		up_sum     = {2'b00, cur.exposure} + {4'b0000, cfg.step_size};
		exp_down   = ({2'b00, cur.exposure} < down_floor) ? EXP_MIN :
		             (cur.exposure - {2'b00, cfg.step_size});
		exp_up     = (up_sum > {2'b00, EXP_MAX}) ? EXP_MAX : up_sum[EXP_W-1:0];
	end

	// Frame decision: the over test is checked first and wins.
	always_comb begin
		is_over  = score_new > cfg.over_limit;
		is_under = !is_over && (score_new < cfg.under_limit);
		res.frame_score = score_new;
		if (is_over) begin
			res.verdict        = VERDICT_OVER;
			res.exposure_value = exp_down;
		end else if (is_under) begin
			res.verdict        = VERDICT_UNDER;
			res.exposure_value = exp_up;
		end else begin
			res.verdict        = VERDICT_OK;
			res.exposure_value = cur.exposure;
		end
	end

	// Next state: the frame end clears score and column and takes the new exposure value.
	always_comb begin
		if (frame_end) begin
			nxt.score    = '0;
			nxt.column   = '0;
			nxt.exposure = res.exposure_value;
		end else begin
			nxt.score    = score_new;
			nxt.column   = col_new;
			nxt.exposure = cur.exposure;
		end
	end

endmodule

@@ design/zone_metered_exposure_stepper_top.sv @@
// Top level of the zone-metered exposure stepper: registers, handshakes and configuration.
//
// Channel  | Direction | Handshake          | Payload
// s_*      | in        | s_tvalid/s_tready  | s_tdata: level; s_tlast: frame_end
// m_*      | out       | m_tvalid/m_tready  | m_tdata: verdict, frame_score, exposure_value
// cfg_*    | in        | cfg_we             | cfg_index, cfg_wdata
//
// A request is loaded into the input register and evaluated there; for a frame-end request
// the result is then loaded into the result register once that register is free.
// One request per cycle is taken while none waits; score and column feed back via state_q.
// A frame-end request waits in the input register only while a result is held by m_tready.
// Reset clears the valid flags and the running score and column, loads the configuration
// defaults and sets the exposure to the minimum; no clearing pass is needed.
module zone_metered_exposure_stepper_top #(
	parameter int unsigned MIN_EXPOSURE_VALUE = 50,
	parameter int unsigned MAX_EXPOSURE_VALUE = 300
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// s_tdata: level [7:0]
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [zmes_pkg::S_DATA_W-1:0]     s_tdata,
	input  logic                              s_tlast,
	// m_tdata: verdict [1:0], frame_score [9:2], exposure_value [19:10], zeros [23:20]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [zmes_pkg::M_DATA_W-1:0]     m_tdata,
	input  logic                              cfg_we,
	input  logic [zmes_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [zmes_pkg::CFG_W-1:0]        cfg_wdata
);
	import zmes_pkg::*;

	localparam logic [EXP_W-1:0] EXP_MIN = EXP_W'(MIN_EXPOSURE_VALUE);

	cfg_t                 cfg_q;
	state_t               state_q;
	state_t               state_nxt;
	result_t              res_nxt;
	result_t              res_q;
	logic                 out_valid_q;
	logic                 valid_s1;
	logic [LEVEL_W-1:0]   level_s1;
	logic                 last_s1;
	logic                 out_free;
	logic                 fire_s1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_length     <= LEN_W'(4);
			cfg_q.window_offset  <= COL_W'(1);
			cfg_q.window_width   <= LEN_W'(2);
			cfg_q.low_threshold  <= LEVEL_W'(48);
			cfg_q.high_threshold <= LEVEL_W'(96);
			cfg_q.over_limit     <= SCORE_W'(18);
			cfg_q.under_limit    <= SCORE_W'(10);
			cfg_q.step_size      <= STEP_W'(5);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ROW_LENGTH:     cfg_q.row_length     <= cfg_wdata[LEN_W-1:0];
				REG_WINDOW_OFFSET:  cfg_q.window_offset  <= cfg_wdata[COL_W-1:0];
				REG_WINDOW_WIDTH:   cfg_q.window_width   <= cfg_wdata[LEN_W-1:0];
				REG_LOW_THRESHOLD:  cfg_q.low_threshold  <= cfg_wdata[LEVEL_W-1:0];
				REG_HIGH_THRESHOLD: cfg_q.high_threshold <= cfg_wdata[LEVEL_W-1:0];
				REG_OVER_LIMIT:     cfg_q.over_limit     <= cfg_wdata[SCORE_W-1:0];
				REG_UNDER_LIMIT:    cfg_q.under_limit    <= cfg_wdata[SCORE_W-1:0];
				REG_STEP_SIZE:      cfg_q.step_size      <= cfg_wdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1 advances unless it holds a frame end and a result is held by m_tready.
	assign out_free = !out_valid_q || m_tready;
	assign fire_s1  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || fire_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			level_s1 <= s_tdata[LEVEL_W-1:0];
			last_s1  <= s_tlast;
		end
	end

	// Scoring and exposure decision.
	zmes_eval #(
		.MIN_EXPOSURE_VALUE(MIN_EXPOSURE_VALUE),
		.MAX_EXPOSURE_VALUE(MAX_EXPOSURE_VALUE)
	) u_eval (
		.cfg       (cfg_q),
		.cur       (state_q),
		.level     (level_s1),
		.frame_end (last_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	// Running state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.score    <= '0;
			state_q.column   <= '0;
			state_q.exposure <= EXP_MIN;
		end else if (fire_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_DATA_W - EXP_W - SCORE_W - 2){1'b0}},
	                   res_q.exposure_value, res_q.frame_score, res_q.verdict};

endmodule

@@ design/zmes_checker.sv @@
// Port-level checker for the zone-metered exposure stepper, with its bind.
module zmes_checker #(
	parameter int unsigned MIN_EXPOSURE_VALUE = 50
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              s_tlast,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [zmes_pkg::M_DATA_W-1:0]     m_tdata
);
	import zmes_pkg::*;

	logic [EXP_W-1:0] last_exp_q;

	// Exposure as last reported, starting from the minimum after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_exp_q <= EXP_W'(MIN_EXPOSURE_VALUE);
		end else if (m_tvalid && m_tready) begin
			last_exp_q <= m_tdata[EXP_W+SCORE_W+1:SCORE_W+2];
		end
	end

	// A held result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
	else $error("result changed while stalled");

	// A new result must follow a taken frame-end request.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
	else $error("result without a frame-end request");

	// A frame judged correct leaves the exposure as it was.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && (m_tdata[1:0] == VERDICT_OK)
		|-> m_tdata[EXP_W+SCORE_W+1:SCORE_W+2] == last_exp_q)
	else $error("exposure moved on a correct frame");

	// No result appears without an input request taken before it.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && !(s_tvalid && s_tready) && !$past(s_tvalid && s_tready)
		|=> !m_tvalid)
	else $error("result appeared too early");

endmodule

bind zone_metered_exposure_stepper_top zmes_checker #(
	.MIN_EXPOSURE_VALUE(MIN_EXPOSURE_VALUE)
) u_zmes_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ sim/testbench.sv @@
// Self-checking testbench for the zone-metered exposure stepper: directed and random frames.
`timescale 1ns / 1ps

module testbench;
	import zmes_pkg::*;

	localparam int     MIN_EXP       = 50;
	localparam int     MAX_EXP       = 300;
	localparam int     SETTLE_CYCLES = 6;
	localparam int     HOLD_CYCLES   = 300;
	localparam int     MAX_REPORTS   = 40;
	localparam longint RUN_LIMIT_NS  = 5_000_000;

	// Ways the result side may stall.
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_LIGHT
	} rx_style_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata   = '0;
	logic                 s_tlast   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	// Local copy of the configuration and running state of the stepper.
	cfg_t      meter_cfg;
	int        score_acc;
	int        zone_col;
	int        exposure_acc;
	result_t   expected_verdicts[$];
	int        mismatch_count = 0;

	// Sender and receiver pacing.
	int        burst_left = 0;
	int        gap_max    = 5;
	logic      hold_trig  = 1'b0;
	logic      hold_seen  = 1'b0;
	int        hold_left  = 0;
	int        rx_cycle   = 0;
	rx_style_t rx_style   = RX_OPEN;

	zone_metered_exposure_stepper_top #(
		.MIN_EXPOSURE_VALUE(MIN_EXP),
		.MAX_EXPOSURE_VALUE(MAX_EXP)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic cfg_t make_cfg(input int row, input int offset, input int width,
			input int lo, input int hi, input int over, input int under, input int step);
		cfg_t c;
		c.row_length     = LEN_W'(row);
		c.window_offset  = COL_W'(offset);
		c.window_width   = LEN_W'(width);
		c.low_threshold  = LEVEL_W'(lo);
		c.high_threshold = LEVEL_W'(hi);
		c.over_limit     = SCORE_W'(over);
		c.under_limit    = SCORE_W'(under);
		c.step_size      = STEP_W'(step);
		return c;
	endfunction

	// Mostly sensible settings, with the full range of every register now and then.
	function automatic cfg_t random_cfg();
		int row;
		int offset;
		int width;
		int lo;
		int hi;
		int over;
		int under;
		int step;
		row    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
		offset = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
		width  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
		lo     = $urandom_range(0, 255);
		hi     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(lo, 255);
		over   = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
			: int'($urandom_range(0, 24)) - 4;
		under  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
			: over - int'($urandom_range(0, 10));
		step   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
		return make_cfg(row, offset, width, lo, hi, over, under, step);
	endfunction

	// Scores one zone byte and, on the frame end, works out the exposure decision.
	function automatic bit meter_zone(input logic [LEVEL_W-1:0] lvl, input bit frame_last,
			output result_t res);
		int row_len;
		int win_lo;
		int win_hi;
		int over_lim;
		int under_lim;
		int step;
		res = '0;
		row_len = meter_cfg.row_length;
		if (row_len == 0) row_len = 1;
		if (row_len > 16) row_len = 16;
		win_lo = meter_cfg.window_offset;
		win_hi = win_lo + meter_cfg.window_width;

		if (zone_col >= win_lo && zone_col < win_hi) begin
			if (lvl < meter_cfg.low_threshold) score_acc = score_acc - 1;
			else if (lvl > meter_cfg.high_threshold) score_acc = score_acc + 2;
			else score_acc = score_acc + 1;
			if (score_acc > 127) score_acc = 127;
			if (score_acc < -128) score_acc = -128;
		end
		zone_col = (zone_col + 1 >= row_len) ? 0 : zone_col + 1;

		if (!frame_last) return 1'b0;

		// Overexposure is tested first, so it wins when both limits are met.
		over_lim  = $signed(meter_cfg.over_limit);
		under_lim = $signed(meter_cfg.under_limit);
		step      = meter_cfg.step_size;
		res.verdict = VERDICT_OK;
		if (score_acc > over_lim) begin
			res.verdict = VERDICT_OVER;
			if (exposure_acc < step + MIN_EXP) exposure_acc = MIN_EXP;
			else exposure_acc = exposure_acc - step;
		end else if (score_acc < under_lim) begin
			res.verdict = VERDICT_UNDER;
			if (exposure_acc + step > MAX_EXP) exposure_acc = MAX_EXP;
			else exposure_acc = exposure_acc + step;
		end
		res.frame_score    = SCORE_W'(score_acc);
		res.exposure_value = EXP_W'(exposure_acc);
		score_acc = 0;
		zone_col  = 0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
	endtask

	// Offers one request; the sender runs in bursts with random gaps between them.
	task automatic send_zone(input logic [LEVEL_W-1:0] lvl, input bit frame_last);
		int gap;
		result_t res;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, gap_max);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= lvl;
		s_tlast  <= frame_last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (meter_zone(lvl, frame_last, res)) expected_verdicts.push_back(res);
	endtask

	// Sends a frame of random levels, some of them at or next to the thresholds.
	task automatic send_frame(input int n_zones);
		logic [LEVEL_W-1:0] lvl;
		for (int i = 0; i < n_zones; i++) begin
			case ($urandom_range(0, 7))
				0:       lvl = LEVEL_W'(meter_cfg.low_threshold + $urandom_range(0, 2) - 1);
				1:       lvl = LEVEL_W'(meter_cfg.high_threshold + $urandom_range(0, 2) - 1);
				default: lvl = LEVEL_W'($urandom_range(0, 255));
			endcase
			send_zone(lvl, i == n_zones - 1);
		end
	endtask

	// Stops the sender and waits until the block has nothing left in flight.
	task automatic settle_block();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// Writes the whole register set while the block is idle.
	task automatic load_config(input cfg_t c);
		settle_block();
		write_reg(REG_ROW_LENGTH,     CFG_W'(c.row_length));
		write_reg(REG_WINDOW_OFFSET,  CFG_W'(c.window_offset));
		write_reg(REG_WINDOW_WIDTH,   CFG_W'(c.window_width));
		write_reg(REG_LOW_THRESHOLD,  CFG_W'(c.low_threshold));
		write_reg(REG_HIGH_THRESHOLD, CFG_W'(c.high_threshold));
		write_reg(REG_OVER_LIMIT,     CFG_W'(c.over_limit));
		write_reg(REG_UNDER_LIMIT,    CFG_W'(c.under_limit));
		write_reg(REG_STEP_SIZE,      CFG_W'(c.step_size));
		cfg_we <= 1'b0;
		meter_cfg = c;
	endtask

	// One frame on the reset settings: each threshold edge, scored and unscored columns.
	task automatic test_reset_defaults();
		send_zone(8'd0, 1'b0);
		send_zone(8'd47, 1'b0);
		send_zone(8'd97, 1'b0);
		send_zone(8'd255, 1'b0);
		send_zone(8'd48, 1'b0);
		send_zone(8'd96, 1'b1);
	endtask

	// Drives the exposure into its upper clamp, then down to the lower one.
	task automatic test_exposure_clamps();
		load_config(make_cfg(0, 0, 1, 0, 255, 127, 127, 255));
		send_zone(8'd255, 1'b1);
		send_zone(8'd0, 1'b1);
		// Both limits met at once: overexposure takes precedence.
		load_config(make_cfg(0, 0, 1, 0, 255, -128, 127, 255));
		send_zone(8'd128, 1'b1);
		send_zone(8'd1, 1'b1);
	endtask

	// Empty window, oversized row length and the last column of the widest row.
	task automatic test_window_edges();
		load_config(make_cfg(31, 15, 0, 128, 128, 0, 0, 0));
		send_zone(8'hFF, 1'b0);
		send_zone(8'h00, 1'b1);
		load_config(make_cfg(20, 15, 16, 128, 128, 0, 0, 7));
		for (int i = 0; i < 16; i++)
			send_zone((i == 15) ? 8'd0 : LEVEL_W'($urandom_range(0, 255)), i == 15);
	endtask

	// Long frames with every zone scored push the score into both saturation bounds.
	task automatic test_saturation();
		load_config(make_cfg(1, 0, 1, 0, 0, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255)));
		send_frame($urandom_range(130, 180));
		load_config(make_cfg(1, 0, 1, 255, 255, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255)));
		send_frame($urandom_range(230, 270));
	endtask

	task automatic test_random_frames();
		int sent;
		int n_zones;
		for (int phase = 0; phase < 13; phase++) begin
			load_config(random_cfg());
			sent = 0;
			while (sent < 55) begin
				n_zones = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12);
				send_frame(n_zones);
				sent += n_zones;
			end
		end
	endtask

	// The result side holds off for a long stretch while frame ends keep coming.
	task automatic test_output_backpressure();
		load_config(random_cfg());
		gap_max = 0;
		hold_trig <= ~hold_trig;
		for (int i = 0; i < 48; i++)
			send_zone(LEVEL_W'($urandom_range(0, 255)), 1'b1);
		gap_max = 5;
	endtask

	// Result-side stall pattern, with a long hold-off on request of a test.
	always @(posedge clk) begin
		if (hold_trig != hold_seen) begin
			hold_seen <= hold_trig;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle % 64 == 0) rx_style <= rx_style_t'($urandom_range(0, 3));
			case (rx_style)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready <= (rx_cycle % 4 == 0);
				default:   m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Compares every accepted result with the oldest expected one.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch("unexpected result", int'(m_tdata), 0);
			end else begin
				want = expected_verdicts.pop_front();
				if (m_tdata[1:0] != want.verdict)
					report_mismatch("verdict", int'(m_tdata[1:0]), int'(want.verdict));
				if ($signed(m_tdata[9:2]) != want.frame_score)
					report_mismatch("frame score", int'($signed(m_tdata[9:2])),
						int'(want.frame_score));
				if (m_tdata[19:10] != want.exposure_value)
					report_mismatch("exposure", int'(m_tdata[19:10]),
						int'(want.exposure_value));
				if (m_tdata[23:20] != '0)
					report_mismatch("padding", int'(m_tdata[23:20]), 0);
			end
		end
	end

	initial begin : run_tests
		meter_cfg    = make_cfg(4, 1, 2, 48, 96, 18, 10, 5);
		score_acc    = 0;
		zone_col     = 0;
		exposure_acc = MIN_EXP;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_exposure_clamps();
		test_window_edges();
		test_saturation();
		test_random_frames();
		test_output_backpressure();
		settle_block();

		if (mismatch_count == 0) begin
			$display("[zone_metered_exposure_stepper_top] OK");
		end else begin
			$display("[zone_metered_exposure_stepper_top] ERROR");
		end
		$finish;
	end

	// Ends a run that hangs.
	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("[zone_metered_exposure_stepper_top] ERROR");
		$finish;
	end

endmodule
